### rtl/core/jte_pkg.sv
// Package for the job table engine: table sizes, field widths, action and
// status codes and the sequencer state type.
// No dependencies; imported by job_table_engine.
`default_nettype none

package jte_pkg;

    // Table geometry and stored field widths.
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int PID_BITS    = 22;
    localparam int PID_FIELD_W = 22;
    localparam int JID_W       = 5;
    localparam int STATE_W     = 2;

    // Stream widths.
    localparam int ACT_W    = 3;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;

    // Run state that marks a foreground job.
    localparam logic [STATE_W-1:0] FG_STATE = 2'd1;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD      = 3'd0,
        ACT_DELETE   = 3'd1,
        ACT_FIND_PID = 3'd2,
        ACT_FIND_JID = 3'd3,
        ACT_FIND_FG  = 3'd4,
        ACT_SET_PID  = 3'd5,
        ACT_SET_JID  = 3'd6,
        ACT_UNUSED   = 3'd7
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 2'd0,
        STS_NOMATCH = 2'd1,
        STS_BADKEY  = 2'd2,
        STS_FULL    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_SCAN    = 4'b0010,
        ST_MAXSCAN = 4'b0100,
        ST_DONE    = 4'b1000
    } seq_state_t;

endpackage

`default_nettype wire

### rtl/core/job_table_engine.sv
// Job table engine: a table of job entries searched one slot per cycle by a
// single shared compare unit under a small sequencer.
// Depends on jte_pkg.
//
// Usage
// The slave channel (s_tvalid, s_tready, s_tuser, s_tdata) carries one
// action per transfer; the master channel (m_tvalid, m_tready, m_tuser,
// m_tdata) returns exactly one result per action, in order.
// s_tready is high only while the sequencer is idle; the block works on one
// action at a time. Rejected keys and the unused action skip the table walk
// and go straight to the final state. Other actions walk the table one slot
// per cycle through the shared compare unit and stop at the first match or
// at the last slot. A delete that hits then walks the whole table again,
// comparing job ids, to find the largest live job id. The result waits in
// an output register; the block goes back to idle and takes the next action
// while it waits. If the receiver still stalls when the next result is
// ready, the sequencer holds in its final state.
// Reset clears every slot at once (slots free, job ids and state
// zero) and sets the next job id to one; no clearing pass is needed.
`default_nettype none

module job_table_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Action transfer.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [jte_pkg::ACT_W-1:0]  s_tuser,  // [2:0] action
    input  wire logic [jte_pkg::DATA_W-1:0] s_tdata,  // [21:0] proc_id, [26:22] job_id,
                                                      // [28:27] run_state, [31:29] zero
    // Result transfer.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [jte_pkg::STATUS_W-1:0]    m_tuser,  // [1:0] status
    output logic [jte_pkg::DATA_W-1:0]      m_tdata   // [21:0] found_pid, [26:22] found_jid,
                                                      // [28:27] found_state, [31:29] zero
);
    import jte_pkg::*;

    // Table storage, cleared by reset.
    logic [PID_BITS-1:0] slot_pid_reg   [TABLE_DEPTH];
    logic [JID_W-1:0]    slot_jid_reg   [TABLE_DEPTH];
    logic [STATE_W-1:0]  slot_state_reg [TABLE_DEPTH];
    logic [JID_W-1:0]    next_jid_reg, next_jid_next;

    // Sequencer and the held action.
    seq_state_t          state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    action_t             act_reg, act_next;
    logic [PID_BITS-1:0] key_pid_reg, key_pid_next;
    logic [JID_W-1:0]    key_jid_reg, key_jid_next;
    logic [STATE_W-1:0]  key_state_reg, key_state_next;
    logic [JID_W-1:0]    max_jid_reg, max_jid_next;

    // Result waiting for the output register.
    status_t             res_status_reg, res_status_next;
    logic [PID_BITS-1:0] res_pid_reg, res_pid_next;
    logic [JID_W-1:0]    res_jid_reg, res_jid_next;
    logic [STATE_W-1:0]  res_state_reg, res_state_next;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [PID_BITS-1:0] out_pid_reg, out_pid_next;
    logic [JID_W-1:0]    out_jid_reg, out_jid_next;
    logic [STATE_W-1:0]  out_state_reg, out_state_next;

    // Slot write strobes.
    logic                wr_en;
    logic [PID_BITS-1:0] wr_pid;
    logic [JID_W-1:0]    wr_jid;
    logic [STATE_W-1:0]  wr_state;

    // Unpacked input fields.
    action_t             in_act;
    logic [PID_BITS-1:0] in_pid;
    logic [JID_W-1:0]    in_jid;
    logic [STATE_W-1:0]  in_state;

    // Shared compare unit on the slot under the scan index.
    logic [PID_BITS-1:0] cur_pid;
    logic [JID_W-1:0]    cur_jid;
    logic [STATE_W-1:0]  cur_state;
    logic                hit;
    logic                last_slot;
    logic [JID_W-1:0]    jid_inc;
    logic                out_free;

    assign in_act   = action_t'(s_tuser);
    assign in_pid   = PID_BITS'(s_tdata[PID_FIELD_W-1:0]);
    assign in_jid   = s_tdata[PID_FIELD_W +: JID_W];
    assign in_state = s_tdata[PID_FIELD_W + JID_W +: STATE_W];

    assign cur_pid   = slot_pid_reg[idx_reg];
    assign cur_jid   = slot_jid_reg[idx_reg];
    assign cur_state = slot_state_reg[idx_reg];
    assign last_slot = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign jid_inc   = next_jid_reg + JID_W'(1);
    assign out_free  = !m_valid_reg || m_tready;

    // Match condition for the held action.
    always_comb
    begin
        unique case (act_reg)
            ACT_ADD:                              hit = (cur_pid == '0);
            ACT_DELETE, ACT_FIND_PID, ACT_SET_PID: hit = (cur_pid == key_pid_reg);
            ACT_FIND_JID, ACT_SET_JID:            hit = (cur_jid == key_jid_reg);
            ACT_FIND_FG:                          hit = (cur_state == FG_STATE);
            default:                              hit = 1'b0;
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        act_next        = act_reg;
        key_pid_next    = key_pid_reg;
        key_jid_next    = key_jid_reg;
        key_state_next  = key_state_reg;
        max_jid_next    = max_jid_reg;
        next_jid_next   = next_jid_reg;
        res_status_next = res_status_reg;
        res_pid_next    = res_pid_reg;
        res_jid_next    = res_jid_reg;
        res_state_next  = res_state_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_pid_next    = out_pid_reg;
        out_jid_next    = out_jid_reg;
        out_state_next  = out_state_reg;
        wr_en           = 1'b0;
        wr_pid          = cur_pid;
        wr_jid          = cur_jid;
        wr_state        = cur_state;
        s_tready        = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next        = in_act;
                    key_pid_next    = in_pid;
                    key_jid_next    = in_jid;
                    key_state_next  = in_state;
                    idx_next        = '0;
                    max_jid_next    = '0;
                    res_status_next = STS_NOMATCH;
                    res_pid_next    = '0;
                    res_jid_next    = '0;
                    res_state_next  = '0;
                    // Rejected keys and the unused action finish at once.
                    priority if (in_act == ACT_UNUSED)
                    begin
                        state_next = ST_DONE;
                    end
                    else if ((in_act == ACT_FIND_JID || in_act == ACT_SET_JID)
                             && in_jid == '0)
                    begin
                        res_status_next = STS_BADKEY;
                        state_next      = ST_DONE;
                    end
                    else if (in_act != ACT_FIND_JID && in_act != ACT_SET_JID
                             && in_act != ACT_FIND_FG && in_pid == '0)
                    begin
                        res_status_next = STS_BADKEY;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                idx_next = idx_reg + IDX_W'(1);
                if (hit)
                begin
                    res_status_next = STS_OK;
                    res_pid_next    = cur_pid;
                    res_jid_next    = cur_jid;
                    res_state_next  = cur_state;
                    state_next      = ST_DONE;
                    unique case (act_reg)
                        ACT_ADD:
                        begin
                            wr_en          = 1'b1;
                            wr_pid         = key_pid_reg;
                            wr_jid         = next_jid_reg;
                            wr_state       = key_state_reg;
                            res_pid_next   = key_pid_reg;
                            res_jid_next   = next_jid_reg;
                            res_state_next = key_state_reg;
                            if (int'(jid_inc) > TABLE_DEPTH)
                            begin
                                next_jid_next = JID_W'(1);
                            end
                            else
                            begin
                                next_jid_next = jid_inc;
                            end
                        end
                        ACT_DELETE:
                        begin
                            wr_en          = 1'b1;
                            wr_pid         = '0;
                            wr_jid         = '0;
                            wr_state       = '0;
                            res_state_next = '0;
                            idx_next       = '0;
                            state_next     = ST_MAXSCAN;
                        end
                        ACT_SET_PID, ACT_SET_JID:
                        begin
                            wr_en          = 1'b1;
                            wr_state       = key_state_reg;
                            res_state_next = key_state_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (last_slot)
                begin
                    res_status_next = (act_reg == ACT_ADD) ? STS_FULL : STS_NOMATCH;
                    state_next      = ST_DONE;
                end
            end

            ST_MAXSCAN:
            begin
                // Largest live job id, one slot per cycle.
                idx_next = idx_reg + IDX_W'(1);
                if (cur_jid > max_jid_reg)
                begin
                    max_jid_next = cur_jid;
                end
                if (last_slot)
                begin
                    next_jid_next = ((cur_jid > max_jid_reg) ? cur_jid : max_jid_reg)
                                    + JID_W'(1);
                    state_next    = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_pid_next    = res_pid_reg;
                    out_jid_next    = res_jid_reg;
                    out_state_next  = res_state_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and next job id registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            next_jid_reg <= JID_W'(1);
        end
        else
        begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            next_jid_reg <= next_jid_next;
        end
    end

    // Table slots: one write port at the scan index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                slot_pid_reg[i]   <= '0;
                slot_jid_reg[i]   <= '0;
                slot_state_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            slot_pid_reg[idx_reg]   <= wr_pid;
            slot_jid_reg[idx_reg]   <= wr_jid;
            slot_state_reg[idx_reg] <= wr_state;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        act_reg        <= act_next;
        key_pid_reg    <= key_pid_next;
        key_jid_reg    <= key_jid_next;
        key_state_reg  <= key_state_next;
        max_jid_reg    <= max_jid_next;
        res_status_reg <= res_status_next;
        res_pid_reg    <= res_pid_next;
        res_jid_reg    <= res_jid_next;
        res_state_reg  <= res_state_next;
        out_status_reg <= out_status_next;
        out_pid_reg    <= out_pid_next;
        out_jid_reg    <= out_jid_next;
        out_state_reg  <= out_state_next;
    end

    // Result transfer.
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {
        (DATA_W - PID_FIELD_W - JID_W - STATE_W)'(0),
        out_state_reg,
        out_jid_reg,
        PID_FIELD_W'(out_pid_reg)
    };

endmodule

`default_nettype wire

### verif/tb_job_table_engine.sv
// Self-checking testbench for job_table_engine: drives actions on the slave stream, checks
// every result on the master stream against a shadow copy of the job table.
// Depends on jte_pkg and the job_table_engine RTL.
`timescale 1ns / 100ps

// Shadow of the job table: works out the reply to each accepted action and checks replies
// in order as they come back from the block.
class job_table_shadow;

    typedef struct packed {
        jte_pkg::status_t                    status;
        logic [jte_pkg::PID_FIELD_W-1:0]     pid;
        logic [jte_pkg::JID_W-1:0]           jid;
        logic [jte_pkg::STATE_W-1:0]         run;
    } reply_t;

    logic [jte_pkg::PID_FIELD_W-1:0] slot_pid   [jte_pkg::TABLE_DEPTH];
    logic [jte_pkg::JID_W-1:0]       slot_jid   [jte_pkg::TABLE_DEPTH];
    logic [jte_pkg::STATE_W-1:0]     slot_run   [jte_pkg::TABLE_DEPTH];
    int                              next_jid;
    reply_t                          replies_due[$];
    int                              mismatches;

    // Every slot free and the job id counter back at one, as after reset.
    function void clear_slots();
        for (int i = 0; i < jte_pkg::TABLE_DEPTH; i++)
        begin
            slot_pid[i] = '0;
            slot_jid[i] = '0;
            slot_run[i] = '0;
        end
        next_jid   = 1;
        mismatches = 0;
        replies_due.delete();
    endfunction

    // First slot holding the given pid, or -1; pid zero finds the first free slot.
    function int slot_of_pid(logic [jte_pkg::PID_FIELD_W-1:0] pid);
        for (int i = 0; i < jte_pkg::TABLE_DEPTH; i++)
            if (slot_pid[i] == pid)
                return i;
        return -1;
    endfunction

    // Apply one accepted action to the shadow table and queue the reply it must give.
    function void apply_action(jte_pkg::action_t act,
                               logic [jte_pkg::PID_FIELD_W-1:0] pid_in,
                               logic [jte_pkg::JID_W-1:0] jid,
                               logic [jte_pkg::STATE_W-1:0] run);
        logic [jte_pkg::PID_FIELD_W-1:0] mask;
        logic [jte_pkg::PID_FIELD_W-1:0] pid;
        logic [jte_pkg::JID_W-1:0]       top;
        reply_t                          r;
        int                              hit;
        bit                              lookup;

        mask = '1;
        if (jte_pkg::PID_BITS < jte_pkg::PID_FIELD_W)
            mask = mask >> (jte_pkg::PID_FIELD_W - jte_pkg::PID_BITS);
        pid      = pid_in & mask;
        r.status = jte_pkg::STS_NOMATCH;
        r.pid    = '0;
        r.jid    = '0;
        r.run    = '0;
        hit      = -1;
        lookup   = 1'b0;

        case (act)
            jte_pkg::ACT_ADD:
            begin
                if (pid == '0)
                    r.status = jte_pkg::STS_BADKEY;
                else
                begin
                    hit = slot_of_pid('0);
                    if (hit < 0)
                        r.status = jte_pkg::STS_FULL;
                    else
                    begin
                        slot_pid[hit] = pid;
                        slot_run[hit] = run;
                        slot_jid[hit] = next_jid[jte_pkg::JID_W-1:0];
                        next_jid = (next_jid + 1) & ((1 << jte_pkg::JID_W) - 1);
                        if (next_jid > jte_pkg::TABLE_DEPTH)
                            next_jid = 1;
                        r.status = jte_pkg::STS_OK;
                        r.pid    = slot_pid[hit];
                        r.jid    = slot_jid[hit];
                        r.run    = slot_run[hit];
                    end
                end
            end
            jte_pkg::ACT_DELETE:
            begin
                if (pid == '0)
                    r.status = jte_pkg::STS_BADKEY;
                else
                begin
                    hit = slot_of_pid(pid);
                    if (hit >= 0)
                    begin
                        r.status = jte_pkg::STS_OK;
                        r.pid    = slot_pid[hit];
                        r.jid    = slot_jid[hit];
                        slot_pid[hit] = '0;
                        slot_jid[hit] = '0;
                        slot_run[hit] = '0;
                        // The next id follows the largest job id still live.
                        top = '0;
                        for (int i = 0; i < jte_pkg::TABLE_DEPTH; i++)
                            if (slot_jid[i] > top)
                                top = slot_jid[i];
                        next_jid = (int'(top) + 1) & ((1 << jte_pkg::JID_W) - 1);
                    end
                end
            end
            jte_pkg::ACT_FIND_PID, jte_pkg::ACT_SET_PID:
            begin
                if (pid == '0)
                    r.status = jte_pkg::STS_BADKEY;
                else
                begin
                    lookup = 1'b1;
                    hit    = slot_of_pid(pid);
                end
            end
            jte_pkg::ACT_FIND_JID, jte_pkg::ACT_SET_JID:
            begin
                if (jid == '0)
                    r.status = jte_pkg::STS_BADKEY;
                else
                begin
                    lookup = 1'b1;
                    for (int i = jte_pkg::TABLE_DEPTH - 1; i >= 0; i--)
                        if (slot_jid[i] == jid)
                            hit = i;
                end
            end
            jte_pkg::ACT_FIND_FG:
            begin
                lookup = 1'b1;
                for (int i = jte_pkg::TABLE_DEPTH - 1; i >= 0; i--)
                    if (slot_run[i] == jte_pkg::FG_STATE)
                        hit = i;
            end
            default:
            begin
            end
        endcase

        // Lookups and state updates report the matched slot after the update.
        if (lookup && hit >= 0)
        begin
            if (act == jte_pkg::ACT_SET_PID || act == jte_pkg::ACT_SET_JID)
                slot_run[hit] = run;
            r.status = jte_pkg::STS_OK;
            r.pid    = slot_pid[hit];
            r.jid    = slot_jid[hit];
            r.run    = slot_run[hit];
        end
        replies_due.push_back(r);
    endfunction

    // Compare one transfer from the block with the oldest reply still due.
    function void check_reply(jte_pkg::status_t status,
                              logic [jte_pkg::PID_FIELD_W-1:0] pid,
                              logic [jte_pkg::JID_W-1:0] jid,
                              logic [jte_pkg::STATE_W-1:0] run);
        reply_t want;

        if (replies_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected reply: status %0d pid %h jid %0d state %0d",
                         status, pid, jid, run);
            return;
        end
        want = replies_due.pop_front();
        if (want.status !== status || want.pid !== pid || want.jid !== jid
            || want.run !== run)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Reply mismatch: expected status %0d pid %h jid %0d state %0d, got status %0d pid %h jid %0d state %0d",
                         want.status, want.pid, want.jid, want.run, status, pid, jid, run);
        end
    endfunction

    function int pending();
        return replies_due.size();
    endfunction

endclass

module tb_job_table_engine;

    import jte_pkg::*;

    localparam int JID_LSB    = PID_FIELD_W;
    localparam int RUN_LSB    = PID_FIELD_W + JID_W;
    localparam int N_RANDOM   = 1825;
    localparam int LONG_HOLD  = 400;
    localparam int POOL_SIZE  = 12;
    localparam int SEGMENT    = 60;
    localparam logic [PID_FIELD_W-1:0] PID_MAX = '1;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [ACT_W-1:0]   s_tuser;
    logic [DATA_W-1:0]  s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [STATUS_W-1:0] m_tuser;
    logic [DATA_W-1:0]  m_tdata;

    job_table_shadow          shadow;
    int                       tx_idle_pct;
    int                       rx_idle_pct;
    bit                       hold_req;
    logic [PID_FIELD_W-1:0]   pid_pool [POOL_SIZE];

    job_table_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    // 4 ns clock.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Offer one action, with random idle cycles ahead of it, and hold it until transferred.
    task automatic send_action(action_t act, logic [PID_FIELD_W-1:0] pid,
                               logic [JID_W-1:0] jid, logic [STATE_W-1:0] run);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(DATA_W - RUN_LSB - STATE_W){1'b0}}, run, jid, pid};
        do
            @(posedge clk);
        while (!s_tready);
        shadow.apply_action(act, pid, jid, run);
    endtask

    // Stop offering and wait until every reply due has come back.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (shadow.pending() != 0);
    endtask

    // One random action: pids mostly from a small pool so that keys hit live entries.
    task automatic random_action(bit filling);
        int                     pick;
        int                     add_cut;
        int                     del_cut;
        action_t                act;
        logic [PID_FIELD_W-1:0] pid;
        logic [JID_W-1:0]       jid;
        logic [STATE_W-1:0]     run;

        add_cut = filling ? 55 : 20;
        del_cut = add_cut + (filling ? 10 : 35);
        pick    = $urandom_range(99);
        if (pick < add_cut)
            act = ACT_ADD;
        else if (pick < del_cut)
            act = ACT_DELETE;
        else
        begin
            act = action_t'($urandom_range(ACT_FIND_PID, ACT_SET_JID));
            if ($urandom_range(49) == 0)
                act = ACT_UNUSED;
        end

        pick = $urandom_range(99);
        if (pick < 3)
            pid = '0;
        else if (pick < 15)
            pid = PID_FIELD_W'($urandom());
        else
            pid = pid_pool[$urandom_range(POOL_SIZE - 1)];
        jid = JID_W'($urandom_range(0, TABLE_DEPTH));
        run = STATE_W'($urandom_range(3));

        // Let the pool drift slowly; the extreme pids stay in it.
        if ($urandom_range(49) == 0)
            pid_pool[$urandom_range(2, POOL_SIZE - 1)] = PID_FIELD_W'($urandom_range(1, 4000));
        send_action(act, pid, jid, run);
    endtask

    // Result receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        int hold_left;

        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Check every result transfer.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            shadow.check_reply(status_t'(m_tuser), m_tdata[PID_FIELD_W-1:0],
                               m_tdata[JID_LSB +: JID_W], m_tdata[RUN_LSB +: STATE_W]);
    end

    // Stimulus.
    initial
    begin
        shadow = new();
        shadow.clear_slots();
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = '0;
        s_tdata     = '0;
        hold_req    = 1'b0;
        tx_idle_pct = 24;
        rx_idle_pct = 47;
        pid_pool[0] = 22'd1;
        pid_pool[1] = PID_MAX;
        for (int i = 2; i < POOL_SIZE; i++)
            pid_pool[i] = PID_FIELD_W'($urandom_range(1, 4000));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, the unused action and every zero key.
        send_action(ACT_FIND_PID, 22'd5, 5'd1, 2'd0);
        send_action(ACT_FIND_FG, 22'd0, 5'd0, 2'd1);
        send_action(ACT_UNUSED, PID_MAX, 5'd16, 2'd3);
        send_action(ACT_ADD, 22'd0, 5'd3, 2'd1);
        send_action(ACT_DELETE, 22'd0, 5'd3, 2'd1);
        send_action(ACT_FIND_PID, 22'd0, 5'd3, 2'd1);
        send_action(ACT_FIND_JID, 22'd7, 5'd0, 2'd1);
        send_action(ACT_SET_PID, 22'd0, 5'd3, 2'd2);
        send_action(ACT_SET_JID, 22'd7, 5'd0, 2'd2);

        // A few entries, one pid added twice, then lookups and updates on them.
        send_action(ACT_ADD, PID_MAX, 5'd0, 2'd3);
        send_action(ACT_ADD, 22'd1, 5'd0, 2'd1);
        send_action(ACT_ADD, PID_MAX, 5'd31, 2'd2);
        send_action(ACT_FIND_FG, 22'd0, 5'd0, 2'd0);
        send_action(ACT_FIND_JID, 22'd0, 5'd16, 2'd0);
        send_action(ACT_SET_JID, 22'd0, 5'd3, 2'd1);
        send_action(ACT_FIND_PID, PID_MAX, 5'd0, 2'd0);
        send_action(ACT_SET_PID, PID_MAX, 5'd0, 2'd0);

        // Deletes, including the duplicate pid and a miss, down to an empty table.
        send_action(ACT_DELETE, 22'd1, 5'd0, 2'd0);
        send_action(ACT_DELETE, PID_MAX, 5'd0, 2'd0);
        send_action(ACT_FIND_JID, 22'd0, 5'd3, 2'd0);
        send_action(ACT_DELETE, 22'd12345, 5'd0, 2'd0);
        send_action(ACT_DELETE, PID_MAX, 5'd0, 2'd0);
        send_action(ACT_FIND_FG, 22'd0, 5'd0, 2'd0);

        // Random part in three idling phases; fill and drain segments alternate.
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 3)
            begin
                wait_drain();
                tx_idle_pct = 47;
                rx_idle_pct = 24;
            end
            else if (i == 2 * N_RANDOM / 3)
            begin
                wait_drain();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (i == 150 || i == 1400)
                hold_req = 1'b1;
            random_action(((i / SEGMENT) % 2) == 0);
        end

        wait_drain();
        repeat (2 * TABLE_DEPTH + 8) @(posedge clk);
        if (shadow.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Run limit.
    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
rtl/core/jte_pkg.sv
rtl/core/job_table_engine.sv
verif/tb_job_table_engine.sv
